// ===== rtl/sqr_pkg.sv =====
// Package for the sorted ready queue: payload structs, command and status codes,
// the per-cell control struct and the ordering compare function.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package sqr_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 3;
    localparam int MODE_W          = 2;
    localparam int COUNT_W         = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK_TIME = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_PRIO = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RESORT    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SHUTDOWN  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLOSED    = 3'd4;

    localparam logic [MODE_W-1:0] MODE_FIFO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

    typedef enum logic {
        KEY_TIME,
        KEY_PRIO
    } key_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_ROTATE
    } cell_op_t;

    typedef struct packed {
        logic [15:0] pid;
        logic [31:0] remaining;
        logic [31:0] arrival;
        logic [7:0]  prio;
    } entry_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [15:0]      in_pid;
        logic [31:0]      in_remaining;
        logic [31:0]      in_arrival;
        logic [7:0]       in_priority;
    } sqr_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [15:0]         out_pid;
        logic [31:0]         out_remaining;
        logic [31:0]         out_arrival;
        logic [7:0]          out_priority;
        logic [COUNT_W-1:0]  count;
    } sqr_rsp_t;

    typedef struct packed {
        cell_op_t          op;
        logic [MODE_W-1:0] mode;
        logic              match_head;
    } cell_ctrl_t;

    // True when entry a orders strictly before entry b under the selected key.
    function automatic logic entry_before(entry_t a, entry_t b, key_t key);
        logic res;
        if (key == KEY_TIME) begin
            if (a.remaining != b.remaining) res = a.remaining < b.remaining;
            else                            res = a.arrival < b.arrival;
        end else begin
            if (a.prio != b.prio) res = a.prio < b.prio;
            else                  res = a.arrival < b.arrival;
        end
        return res;
    endfunction

endpackage

// ===== rtl/sorted_ready_queue.sv =====
// Top level of the sorted ready queue: command/response channels, the order
// mode register, the control sequencer and the chain of entry cells.
// Depends on sqr_pkg, sqr_cell and sqr_prefix.
`timescale 1ns / 1ps

// Usage: a command transaction on cmd_* (valid/stall) carries one command and
// its entry fields; each command yields exactly one response transaction on
// rsp_* with a status, the popped or peeked entry and the entry count.
// The order mode must be written through cfg_valid/cfg_ready/cfg_data only
// while the queue is idle; the user must keep to this, as the block does not
// enforce it. cfg_ready is always high.
// Push, pop, remove, shutdown and a peek or resort of an empty queue are
// answered from S_EXEC. Otherwise a peek rotates the chain once through
// S_PEEK past a single compare at the head, and a resort pops and reinserts
// each entry in turn through S_RES_POP and then S_RES_INS.
// One command is worked on at a time, so a new command is taken only after the
// last one is through; cmd_stall is high while one is in progress.
// A finished response waits in the output register while rsp_stall is high,
// and the next command is accepted meanwhile; its own response is held until
// the output register frees up.
// Reset empties the queue, reopens it and selects FIFO order at once; there
// is no clearing pass.

module sorted_ready_queue
    import sqr_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  sqr_cmd_t          cmd_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sqr_rsp_t          rsp_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MODE_W-1:0] cfg_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE        = CW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RES_POP,
        S_RES_INS,
        S_PEEK,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic               closed_reg;
    logic [CW-1:0]      fill_reg;
    logic [CW-1:0]      fill_next;
    logic [CW-1:0]      cnt_reg;
    logic [CMD_W-1:0]   op_reg;
    entry_t             cand_reg;
    entry_t             best_reg;
    entry_t             best_next;
    logic               first_reg;
    sqr_rsp_t           res_reg;
    sqr_rsp_t           res_c;
    logic               res_fire;
    logic               rsp_valid_reg;
    sqr_rsp_t           rsp_data_reg;
    logic               out_free;
    logic               rsp_load;
    key_t               peek_key;

    cell_ctrl_t         cell_ctrl;
    logic [CW-1:0]      ctrl_lo;
    logic [CW-1:0]      ctrl_hi;
    entry_t             cell_q  [QUEUE_DEPTH];
    entry_t             left_e  [QUEUE_DEPTH];
    entry_t             right_e [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] stop;
    logic [QUEUE_DEPTH-1:0] seen;
    logic               any_stop;

    genvar g;
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign left_e[g] = cand_reg;
        end else begin : g_inner_l
            assign left_e[g] = cell_q[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_e[g] = cand_reg;
        end else begin : g_inner_r
            assign right_e[g] = cell_q[g+1];
        end

        sqr_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .INDEX       (g)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .lo        (ctrl_lo),
            .hi        (ctrl_hi),
            .cand      (cand_reg),
            .left      (left_e[g]),
            .right     (right_e[g]),
            .head      (cell_q[0]),
            .seen_left (seen[g]),
            .stop      (stop[g]),
            .entry     (cell_q[g])
        );
    end

    sqr_prefix #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_prefix (
        .stop     (stop),
        .seen     (seen),
        .any_stop (any_stop)
    );

    assign cmd_stall = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_load  = out_free && (res_fire || state_reg == S_DONE);
    assign peek_key  = (op_reg == CMD_PEEK_TIME) ? KEY_TIME : KEY_PRIO;

    always_comb
    begin
        if (first_reg || entry_before(cell_q[0], best_reg, peek_key)) best_next = cell_q[0];
        else best_next = best_reg;
    end

    always_comb
    begin
        cell_ctrl.op         = OP_HOLD;
        cell_ctrl.mode       = mode_reg;
        cell_ctrl.match_head = 1'b0;
        ctrl_lo              = '0;
        ctrl_hi              = fill_reg;
        case (state_reg)
            S_EXEC:
            begin
                case (op_reg)
                    CMD_PUSH:
                    begin
                        if (!closed_reg && fill_reg != FULL_COUNT) cell_ctrl.op = OP_INSERT;
                    end
                    CMD_POP:
                    begin
                        cell_ctrl.op         = OP_REMOVE;
                        cell_ctrl.match_head = 1'b1;
                    end
                    CMD_REMOVE: cell_ctrl.op = OP_REMOVE;
                    default:    cell_ctrl.op = OP_HOLD;
                endcase
            end
            S_RES_POP:
            begin
                cell_ctrl.op         = OP_REMOVE;
                cell_ctrl.match_head = 1'b1;
            end
            S_RES_INS:
            begin
                cell_ctrl.op = OP_INSERT;
                ctrl_lo      = cnt_reg - ONE;
                ctrl_hi      = fill_reg - ONE;
            end
            S_PEEK:  cell_ctrl.op = OP_ROTATE;
            default: cell_ctrl.op = OP_HOLD;
        endcase
    end

    always_comb
    begin
        res_c        = '0;
        res_c.status = ST_OK;
        res_fire     = 1'b0;
        fill_next    = fill_reg;
        case (state_reg)
            S_EXEC:
            begin
                case (op_reg)
                    CMD_PUSH:
                    begin
                        res_fire = 1'b1;
                        if (closed_reg) res_c.status = ST_CLOSED;
                        else if (fill_reg == FULL_COUNT) res_c.status = ST_FULL;
                        else fill_next = fill_reg + ONE;
                    end
                    CMD_POP:
                    begin
                        res_fire = 1'b1;
                        if (fill_reg == '0) begin
                            res_c.status = ST_EMPTY;
                        end else begin
                            res_c.out_pid       = cell_q[0].pid;
                            res_c.out_remaining = cell_q[0].remaining;
                            res_c.out_arrival   = cell_q[0].arrival;
                            res_c.out_priority  = cell_q[0].prio;
                            fill_next           = fill_reg - ONE;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        res_fire = 1'b1;
                        if (any_stop) fill_next = fill_reg - ONE;
                        else res_c.status = ST_NOT_FOUND;
                    end
                    CMD_PEEK_TIME, CMD_PEEK_PRIO:
                    begin
                        res_fire = fill_reg == '0;
                        res_c.status = ST_EMPTY;
                    end
                    CMD_RESORT: res_fire = fill_reg == '0;
                    default:    res_fire = 1'b1;
                endcase
            end
            S_RES_INS: res_fire = cnt_reg == ONE;
            S_PEEK:
            begin
                res_fire            = cnt_reg == ONE;
                res_c.out_pid       = best_next.pid;
                res_c.out_remaining = best_next.remaining;
                res_c.out_arrival   = best_next.arrival;
                res_c.out_priority  = best_next.prio;
            end
            default: res_fire = 1'b0;
        endcase
        res_c.count = COUNT_W'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_FIFO;
            closed_reg    <= 1'b0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            first_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) mode_reg <= cfg_data;
            if (rsp_load) rsp_valid_reg <= 1'b1;
            else if (!rsp_stall) rsp_valid_reg <= 1'b0;
            fill_reg <= fill_next;

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid) begin
                        op_reg             <= cmd_data.cmd;
                        cand_reg.pid       <= cmd_data.in_pid;
                        cand_reg.remaining <= cmd_data.in_remaining;
                        cand_reg.arrival   <= cmd_data.in_arrival;
                        cand_reg.prio      <= cmd_data.in_priority;
                        state_reg          <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (op_reg == CMD_SHUTDOWN) closed_reg <= 1'b1;
                    if (!res_fire) begin
                        cnt_reg   <= fill_reg;
                        first_reg <= 1'b1;
                        state_reg <= (op_reg == CMD_RESORT) ? S_RES_POP : S_PEEK;
                    end
                end
                S_RES_POP:
                begin
                    cand_reg  <= cell_q[0];
                    state_reg <= S_RES_INS;
                end
                S_RES_INS:
                begin
                    cnt_reg <= cnt_reg - ONE;
                    if (!res_fire) state_reg <= S_RES_POP;
                end
                S_PEEK:
                begin
                    best_reg  <= best_next;
                    first_reg <= 1'b0;
                    cnt_reg   <= cnt_reg - ONE;
                end
                S_DONE:
                begin
                    if (out_free) begin
                        rsp_data_reg <= res_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            if (res_fire) begin
                if (out_free) begin
                    rsp_data_reg <= res_c;
                    state_reg    <= S_IDLE;
                end else begin
                    res_reg   <= res_c;
                    state_reg <= S_DONE;
                end
            end
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_COUNT)
        else $error("Entry count exceeds the queue depth.");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && op_reg == CMD_PUSH && !closed_reg && fill_reg != FULL_COUNT)
        |=> fill_reg == $past(fill_reg) + ONE)
        else $error("Accepted push did not add an entry.");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && op_reg == CMD_REMOVE && any_stop)
        |=> fill_reg == $past(fill_reg) - ONE)
        else $error("Successful remove did not drop an entry.");

    a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PEEK || state_reg == S_RES_POP || state_reg == S_RES_INS)
        |-> cnt_reg != '0)
        else $error("Scan counter ran out while a scan was active.");

    a_closed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("Shutdown flag cleared without reset.");

endmodule

// ===== rtl/sqr_cell.sv =====
// One cell of the queue chain: holds a single entry and takes its next value
// from itself, a neighbor, the head cell or the candidate entry.
// Depends on sqr_pkg.
`timescale 1ns / 1ps

module sqr_cell
    import sqr_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int INDEX       = 0,
    localparam int CW         = $clog2(QUEUE_DEPTH + 1)
)(
    input  logic          clk,
    input  cell_ctrl_t    ctrl,
    input  logic [CW-1:0] lo,
    input  logic [CW-1:0] hi,
    input  entry_t        cand,
    input  entry_t        left,
    input  entry_t        right,
    input  entry_t        head,
    input  logic          seen_left,
    output logic          stop,
    output entry_t        entry
);

    localparam logic [CW-1:0] IDX  = CW'(INDEX);
    localparam logic [CW-1:0] IDX1 = CW'(INDEX + 1);

    entry_t entry_reg;
    entry_t entry_next;
    logic   in_lo;
    logic   below_hi;
    logic   at_hi;
    logic   ordered;
    logic   ahead;

    assign in_lo    = IDX >= lo;
    assign below_hi = IDX < hi;
    assign at_hi    = IDX == hi;

    always_comb
    begin
        ordered = 1'b0;
        ahead   = 1'b0;
        case (ctrl.mode)
            MODE_SJF:
            begin
                ordered = 1'b1;
                ahead   = entry_before(entry_reg, cand, KEY_TIME);
            end
            MODE_PRIO:
            begin
                ordered = 1'b1;
                ahead   = entry_before(entry_reg, cand, KEY_PRIO);
            end
            default:
            begin
                ordered = 1'b0;
                ahead   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        stop = 1'b0;
        case (ctrl.op)
            OP_INSERT: stop = ordered && in_lo && below_hi && !ahead;
            OP_REMOVE: stop = below_hi && (ctrl.match_head ? (IDX == '0)
                                                           : (entry_reg.pid == cand.pid));
            default:   stop = 1'b0;
        endcase
    end

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (in_lo && (below_hi || at_hi)) begin
                    if (seen_left) entry_next = left;
                    else if (stop || at_hi) entry_next = cand;
                end
            end
            OP_REMOVE:
            begin
                if (below_hi && (seen_left || stop)) entry_next = right;
            end
            OP_ROTATE:
            begin
                if (IDX1 == hi) entry_next = head;
                else if (below_hi) entry_next = right;
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/sqr_prefix.sv =====
// Prefix OR across the cell chain: tells each cell whether a cell in front of
// it raised its stop flag. Depends on sqr_pkg.
`timescale 1ns / 1ps

module sqr_prefix
    import sqr_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)(
    input  logic [QUEUE_DEPTH-1:0] stop,
    output logic [QUEUE_DEPTH-1:0] seen,
    output logic                   any_stop
);

    genvar g;
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_seen
        localparam logic [QUEUE_DEPTH-1:0] LOW_MASK = {QUEUE_DEPTH{1'b1}} >> (QUEUE_DEPTH - g);
        assign seen[g] = |(stop & LOW_MASK);
    end

    assign any_stop = |stop;

endmodule
